// ===== design/sfd_pkg.sv =====
package sfd_pkg;

	localparam logic [7:0] DELIM      = 8'hC0;
	localparam logic [7:0] ESC        = 8'hDB;
	localparam logic [7:0] ESC_END    = 8'hDC;
	localparam logic [7:0] ESC_ESC    = 8'hDD;
	localparam logic [7:0] HEADER     = 8'h48;
	localparam logic [15:0] CMD_POWER  = 16'h0132;
	localparam logic [15:0] CMD_ENERGY = 16'h0131;
	localparam logic [7:0] CRC_POLY   = 8'hB5;
	localparam logic [5:0] LEN_MAX    = 6'd63;

	localparam logic [5:0] POS_HEADER = 6'd0;
	localparam logic [5:0] POS_ZERO0  = 6'd1;
	localparam logic [5:0] POS_ZERO1  = 6'd2;
	localparam logic [5:0] POS_ADDR_L = 6'd3;
	localparam logic [5:0] POS_ADDR_H = 6'd4;
	localparam logic [5:0] POS_CMD_H  = 6'd6;
	localparam logic [5:0] POS_CMD_L  = 6'd7;
	localparam logic [5:0] POS_VAL0   = 6'd8;
	localparam logic [5:0] POS_VAL1   = 6'd9;
	localparam logic [5:0] POS_VAL2   = 6'd10;
	localparam logic [5:0] POS_VAL3   = 6'd11;

	localparam logic [5:0] MIN_LEN_ADDR   = 6'd5;
	localparam logic [5:0] MIN_LEN_POWER  = 6'd11;
	localparam logic [5:0] MIN_LEN_ENERGY = 6'd13;

	typedef enum logic [1:0] {
		KIND_OTHER  = 2'd0,
		KIND_POWER  = 2'd1,
		KIND_ENERGY = 2'd2
	} frame_kind_t;

	typedef struct packed {
		logic               overflow;
		logic [5:0]         frame_length;
		logic signed [32:0] reading_value;
		logic               address_ok;
		logic               crc_ok;
		frame_kind_t        frame_kind;
	} result_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== design/sfd_frame_core.sv =====
module sfd_frame_core #(
	parameter int MAX_FRAME_BYTES = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  logic [7:0]       meter_address_low,
	input  logic [7:0]       meter_address_high,
	output logic             close,
	output sfd_pkg::result_t result
);

	localparam logic [5:0] MaxPos = 6'(MAX_FRAME_BYTES);

	logic        in_frame_q, in_frame_d;
	logic        esc_q, esc_d;
	logic [5:0]  pos_q, pos_d;
	logic [7:0]  crc_q, crc_d;
	logic [7:0]  crc_prev_q, crc_prev_d;
	logic [7:0]  last_q, last_d;
	logic        hdr_q, hdr_d;
	logic [15:0] cmd_q, cmd_d;
	logic [31:0] val_q, val_d;
	logic        long_q, long_d;

	logic        take;
	logic [7:0]  tb;

	logic        crc_ok;
	logic        addr_ok;
	sfd_pkg::frame_kind_t kind;
	logic [19:0] ext;
	logic [19:0] power;
	logic signed [32:0] value;

	// frame close result from current state
	always_comb begin
		crc_ok  = (last_q == crc_prev_q);
		addr_ok = hdr_q && (pos_q >= sfd_pkg::MIN_LEN_ADDR);
		if (cmd_q == sfd_pkg::CMD_POWER && pos_q >= sfd_pkg::MIN_LEN_POWER) begin
			kind = sfd_pkg::KIND_POWER;
		end else if (cmd_q == sfd_pkg::CMD_ENERGY && pos_q >= sfd_pkg::MIN_LEN_ENERGY) begin
			kind = sfd_pkg::KIND_ENERGY;
		end else begin
			kind = sfd_pkg::KIND_OTHER;
		end
		ext   = {{4{val_q[15]}}, val_q[15:0]};
		power = (ext << 3) + (ext << 1);
		value = '0;
		if (crc_ok && addr_ok && !long_q) begin
			unique case (kind)
				sfd_pkg::KIND_POWER:  value = {{13{power[19]}}, power};
				sfd_pkg::KIND_ENERGY: value = {1'b0, val_q};
				default:              value = '0;
			endcase
		end
		result.frame_kind    = kind;
		result.crc_ok        = crc_ok;
		result.address_ok    = addr_ok;
		result.reading_value = value;
		result.frame_length  = pos_q;
		result.overflow      = long_q;
	end

	assign close = (rx_byte == sfd_pkg::DELIM) && in_frame_q && (pos_q != 6'd0);

	always_comb begin
		in_frame_d = in_frame_q;
		esc_d      = esc_q;
		pos_d      = pos_q;
		crc_d      = crc_q;
		crc_prev_d = crc_prev_q;
		last_d     = last_q;
		hdr_d      = hdr_q;
		cmd_d      = cmd_q;
		val_d      = val_q;
		long_d     = long_q;
		take       = 1'b0;
		tb         = rx_byte;

		if (rx_byte == sfd_pkg::DELIM) begin
			in_frame_d = 1'b1;
			esc_d      = 1'b0;
			pos_d      = '0;
			crc_d      = '0;
			crc_prev_d = '0;
			last_d     = '0;
			hdr_d      = 1'b1;
			cmd_d      = '0;
			val_d      = '0;
			long_d     = 1'b0;
		end else if (in_frame_q) begin
			esc_d = 1'b0;
			if (esc_q && rx_byte == sfd_pkg::ESC_END) begin
				take = 1'b1;
				tb   = sfd_pkg::DELIM;
			end else if (esc_q && rx_byte == sfd_pkg::ESC_ESC) begin
				take = 1'b1;
				tb   = sfd_pkg::ESC;
			end else if (rx_byte == sfd_pkg::ESC) begin
				esc_d = 1'b1;
			end else begin
				take = 1'b1;
			end
		end

		if (take) begin
			unique case (pos_q)
				sfd_pkg::POS_HEADER: if (tb != sfd_pkg::HEADER) hdr_d = 1'b0;
				sfd_pkg::POS_ZERO0,
				sfd_pkg::POS_ZERO1:  if (tb != 8'h00) hdr_d = 1'b0;
				sfd_pkg::POS_ADDR_L: if (tb != meter_address_low) hdr_d = 1'b0;
				sfd_pkg::POS_ADDR_H: if (tb != meter_address_high) hdr_d = 1'b0;
				sfd_pkg::POS_CMD_H:  cmd_d[15:8] = tb;
				sfd_pkg::POS_CMD_L:  cmd_d[7:0] = tb;
				sfd_pkg::POS_VAL0:   val_d[7:0] = tb;
				sfd_pkg::POS_VAL1:   val_d[15:8] = tb;
				sfd_pkg::POS_VAL2:   val_d[23:16] = tb;
				sfd_pkg::POS_VAL3:   val_d[31:24] = tb;
				default: ;
			endcase
			if (pos_q >= MaxPos) long_d = 1'b1;
			if (pos_q < sfd_pkg::LEN_MAX) pos_d = pos_q + 6'd1;
			crc_prev_d = crc_q;
			crc_d      = sfd_pkg::crc8_step(crc_q, tb);
			last_d     = tb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			pos_q      <= '0;
			crc_q      <= '0;
			crc_prev_q <= '0;
			last_q     <= '0;
			hdr_q      <= 1'b1;
			cmd_q      <= '0;
			val_q      <= '0;
			long_q     <= 1'b0;
		end else if (step) begin
			in_frame_q <= in_frame_d;
			esc_q      <= esc_d;
			pos_q      <= pos_d;
			crc_q      <= crc_d;
			crc_prev_q <= crc_prev_d;
			last_q     <= last_d;
			hdr_q      <= hdr_d;
			cmd_q      <= cmd_d;
			val_q      <= val_d;
			long_q     <= long_d;
		end
	end

endmodule

// ===== design/slip_frame_decoder_crc8_check_top.sv =====
// slip frame decoder with crc-8 and meter reply check
// s_t* carries received line bytes, one per request; 0xc0 delimits frames
// m_t* carries one request per closed non-empty frame: frame kind on m_tuser,
// crc and address checks, reading value, decoded length and overflow flag
// on m_tdata
// apb port: meter_address_low at 0x0, meter_address_high at 0x4, to be
// written by the user only while the block is idle, which the block does
// not enforce; reads return the register value; a closing 0xc0 in the input
// register is decoded into the result register, which raises m_tvalid
// throughput: one byte per cycle unless a closing byte stalls, set by the
// single decode step between the input register and the result register
// a stalled result holds in the result register; bytes that do not close a
// frame keep flowing, a closing byte waits in the input register with
// s_tready low until the result register frees
// reset clears the frame state, both address registers and both valid flags;
// bytes before the first 0xc0 are ignored
module slip_frame_decoder_crc8_check_top #(
	parameter int MAX_FRAME_BYTES = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// crc_ok[0], address_ok[1], reading_value[34:2],
	// frame_length[40:35], overflow[41], zero fill[47:42]
	output logic [47:0] m_tdata,
	output logic [1:0]  m_tuser,   // frame_kind[1:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_valid_q;
	sfd_pkg::result_t out_q;
	logic [7:0]       addr_low_q;
	logic [7:0]       addr_high_q;

	logic             close;
	logic             need_out;
	logic             adv;
	sfd_pkg::result_t result;

	sfd_frame_core #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (adv),
		.rx_byte           (byte_s1),
		.meter_address_low (addr_low_q),
		.meter_address_high(addr_high_q),
		.close             (close),
		.result            (result)
	);

	assign need_out = valid_s1 && close;
	assign adv      = valid_s1 && (!need_out || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && need_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && need_out) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_q.overflow, out_q.frame_length, out_q.reading_value,
		out_q.address_ok, out_q.crc_ok};
	assign m_tuser  = out_q.frame_kind;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_low_q  <= '0;
			addr_high_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2]) begin
				addr_high_q <= pwdata[7:0];
			end else begin
				addr_low_q <= pwdata[7:0];
			end
		end
	end

	assign prdata = paddr[2] ? {24'b0, addr_high_q} : {24'b0, addr_low_q};

endmodule

// ===== sim/slip_frame_decoder_crc8_check_top_tb.sv =====
module slip_frame_decoder_crc8_check_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN = 48;
	localparam logic [2:0] ADDR_METER_LOW  = 3'd0;
	localparam logic [2:0] ADDR_METER_HIGH = 3'd4;

	typedef logic [7:0] byte_q_t[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	slip_frame_decoder_crc8_check_top #(
		.MAX_FRAME_BYTES(MAX_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decoder state mirror
	logic [7:0]  meter_lo_cfg = 8'h00;
	logic [7:0]  meter_hi_cfg = 8'h00;
	logic        frame_open = 1'b0;
	logic        esc_seen = 1'b0;
	logic [5:0]  dec_count = 6'd0;
	logic [7:0]  crc_run = 8'h00;
	logic [7:0]  crc_prev = 8'h00;
	logic [7:0]  last_byte = 8'h00;
	logic        hdr_good = 1'b1;
	logic [15:0] cmd_word = 16'h0000;
	logic [31:0] val_word = 32'h0;
	logic        len_exceeded = 1'b0;

	sfd_pkg::result_t expected_frames[$];
	int errors = 0;
	int frames_checked = 0;
	int line_bytes = 0;
	int address_settings = 0;
	bit steady = 1'b0;

	function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic fb;
		int k;
		c = crc;
		for (k = 7; k >= 0; k--) begin
			fb = c[7] ^ b[k];
			c = {c[6:0], 1'b0};
			if (fb) begin
				c = c ^ sfd_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic void take_decoded(input logic [7:0] b);
		case (dec_count)
			sfd_pkg::POS_HEADER: if (b != sfd_pkg::HEADER) hdr_good = 1'b0;
			sfd_pkg::POS_ZERO0, sfd_pkg::POS_ZERO1: if (b != 8'h00) hdr_good = 1'b0;
			sfd_pkg::POS_ADDR_L: if (b != meter_lo_cfg) hdr_good = 1'b0;
			sfd_pkg::POS_ADDR_H: if (b != meter_hi_cfg) hdr_good = 1'b0;
			sfd_pkg::POS_CMD_H: cmd_word[15:8] = b;
			sfd_pkg::POS_CMD_L: cmd_word[7:0] = b;
			sfd_pkg::POS_VAL0: val_word[7:0] = b;
			sfd_pkg::POS_VAL1: val_word[15:8] = b;
			sfd_pkg::POS_VAL2: val_word[23:16] = b;
			sfd_pkg::POS_VAL3: val_word[31:24] = b;
			default: ;
		endcase
		if (dec_count >= MAX_LEN) begin
			len_exceeded = 1'b1;
		end
		if (dec_count < sfd_pkg::LEN_MAX) begin
			dec_count = dec_count + 6'd1;
		end
		crc_prev = crc_run;
		crc_run = crc_next(crc_run, b);
		last_byte = b;
	endfunction

	function automatic void decode_line_byte(input logic [7:0] b);
		sfd_pkg::result_t r;
		if (b == sfd_pkg::DELIM) begin
			if (frame_open && dec_count != 6'd0) begin
				r.frame_kind = sfd_pkg::KIND_OTHER;
				if (cmd_word == sfd_pkg::CMD_POWER && dec_count >= sfd_pkg::MIN_LEN_POWER) begin
					r.frame_kind = sfd_pkg::KIND_POWER;
				end else if (cmd_word == sfd_pkg::CMD_ENERGY
						&& dec_count >= sfd_pkg::MIN_LEN_ENERGY) begin
					r.frame_kind = sfd_pkg::KIND_ENERGY;
				end
				r.crc_ok = (last_byte == crc_prev);
				r.address_ok = hdr_good && (dec_count >= sfd_pkg::MIN_LEN_ADDR);
				r.reading_value = 33'sd0;
				if (r.frame_kind != sfd_pkg::KIND_OTHER && r.crc_ok && r.address_ok
						&& !len_exceeded) begin
					if (r.frame_kind == sfd_pkg::KIND_POWER) begin
						r.reading_value = $signed(val_word[15:0]) * 33'sd10;
					end else begin
						r.reading_value = {1'b0, val_word};
					end
				end
				r.frame_length = dec_count;
				r.overflow = len_exceeded;
				expected_frames.push_back(r);
			end
			frame_open = 1'b1;
			esc_seen = 1'b0;
			dec_count = 6'd0;
			crc_run = 8'h00;
			crc_prev = 8'h00;
			last_byte = 8'h00;
			hdr_good = 1'b1;
			cmd_word = 16'h0000;
			val_word = 32'h0;
			len_exceeded = 1'b0;
			return;
		end
		if (!frame_open) begin
			return;
		end
		if (esc_seen) begin
			esc_seen = 1'b0;
			if (b == sfd_pkg::ESC_END) begin
				take_decoded(sfd_pkg::DELIM);
				return;
			end
			if (b == sfd_pkg::ESC_ESC) begin
				take_decoded(sfd_pkg::ESC);
				return;
			end
		end
		if (b == sfd_pkg::ESC) begin
			esc_seen = 1'b1;
		end else begin
			take_decoded(b);
		end
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic send_line_byte(input logic [7:0] b);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (s_tready !== 1'b1);
		decode_line_byte(b);
		line_bytes++;
	endtask

	// slip-encode decoded bytes onto the line
	task automatic send_decoded(input byte_q_t dec);
		foreach (dec[i]) begin
			if (dec[i] == sfd_pkg::DELIM) begin
				send_line_byte(sfd_pkg::ESC);
				send_line_byte(sfd_pkg::ESC_END);
			end else if (dec[i] == sfd_pkg::ESC) begin
				send_line_byte(sfd_pkg::ESC);
				send_line_byte(sfd_pkg::ESC_ESC);
			end else begin
				send_line_byte(dec[i]);
			end
		end
	endtask

	task automatic wait_for_idle();
		s_tvalid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] addr, input logic [7:0] value);
		logic [31:0] word;
		word = $urandom;
		word[7:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (addr == ADDR_METER_LOW) begin
			meter_lo_cfg = value;
		end else begin
			meter_hi_cfg = value;
		end
		// read back
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		check_field("prdata", value, prdata[7:0]);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_meter_address(input logic [7:0] lo, input logic [7:0] hi);
		wait_for_idle();
		write_register(ADDR_METER_LOW, lo);
		write_register(ADDR_METER_HIGH, hi);
		address_settings++;
	endtask

	task automatic test_line_escapes();
		byte_q_t seq;
		seq = '{8'h00, 8'hFF, sfd_pkg::ESC, 8'h5A,
			sfd_pkg::DELIM, sfd_pkg::DELIM,
			8'h00, 8'hFF, sfd_pkg::ESC, sfd_pkg::ESC_END, sfd_pkg::ESC, sfd_pkg::ESC_ESC,
			sfd_pkg::ESC, 8'h7E, sfd_pkg::ESC, sfd_pkg::DELIM,
			sfd_pkg::ESC, sfd_pkg::ESC, sfd_pkg::ESC_ESC, sfd_pkg::ESC_END, sfd_pkg::DELIM,
			8'h00, sfd_pkg::DELIM};
		foreach (seq[i]) begin
			send_line_byte(seq[i]);
		end
	endtask

	task automatic test_meter_replies(input int count);
		byte_q_t body;
		int mode;
		int body_len;
		int idx;
		logic [31:0] val;
		logic [15:0] cmd;
		logic [7:0] c;
		send_line_byte(sfd_pkg::DELIM);
		for (int f = 0; f < count; f++) begin
			mode = $urandom_range(0, 9);
			case ($urandom_range(0, 5))
				0: val = 32'h0000_0000;
				1: val = 32'h0000_7FFF;
				2: val = 32'h0000_8000;
				3: val = 32'hFFFF_FFFF;
				4: val = 32'h8000_0000;
				default: val = $urandom;
			endcase
			if ($urandom_range(0, 7) == 0) begin
				cmd = 16'($urandom);
			end else begin
				cmd = $urandom_range(0, 1) ? sfd_pkg::CMD_POWER : sfd_pkg::CMD_ENERGY;
			end
			body = {};
			body.push_back(sfd_pkg::HEADER);
			body.push_back(8'h00);
			body.push_back(8'h00);
			body.push_back(meter_lo_cfg);
			body.push_back(meter_hi_cfg);
			body.push_back(8'($urandom));
			body.push_back(cmd[15:8]);
			body.push_back(cmd[7:0]);
			body.push_back(val[7:0]);
			body.push_back(val[15:8]);
			body.push_back(val[23:16]);
			body.push_back(val[31:24]);
			case (mode)
				6: body_len = $urandom_range(0, 12);
				7: begin
					case ($urandom_range(0, 2))
						0: body_len = MAX_LEN - 1;
						1: body_len = MAX_LEN;
						default: body_len = $urandom_range(MAX_LEN + 1, 70);
					endcase
				end
				8: begin
					body = {};
					body_len = $urandom_range(1, 20);
				end
				default: body_len = ((cmd == sfd_pkg::CMD_POWER) ? 10 : 12)
					+ $urandom_range(0, 3);
			endcase
			while (body.size() > body_len) void'(body.pop_back());
			while (body.size() < body_len) body.push_back(8'($urandom));
			// broken header, zero or address byte
			if (mode == 9) begin
				idx = $urandom_range(0, 4);
				body[idx] = body[idx] ^ (8'h01 << $urandom_range(0, 7));
			end
			c = 8'h00;
			foreach (body[i]) begin
				c = crc_next(c, body[i]);
			end
			if ($urandom_range(0, 9) == 0) begin
				c = c ^ 8'($urandom_range(1, 255));
			end
			body.push_back(c);
			if ($urandom_range(0, 3) == 0) begin
				send_line_byte(sfd_pkg::DELIM);
			end
			send_decoded(body);
			send_line_byte(sfd_pkg::DELIM);
		end
	endtask

	// address registers rewritten while a frame is open
	task automatic test_address_change(input int count);
		byte_q_t body;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] c;
		for (int n = 0; n < count; n++) begin
			lo = 8'($urandom);
			hi = 8'($urandom);
			send_line_byte(sfd_pkg::DELIM);
			body = '{sfd_pkg::HEADER, 8'h00, 8'h00};
			send_decoded(body);
			wait_for_idle();
			write_register(ADDR_METER_LOW, lo);
			body.push_back($urandom_range(0, 1) ? lo : meter_lo_cfg ^ 8'h01);
			send_decoded('{body[3]});
			wait_for_idle();
			write_register(ADDR_METER_HIGH, hi);
			body.push_back($urandom_range(0, 3) != 0 ? hi : ~hi);
			body.push_back(8'($urandom));
			body.push_back(sfd_pkg::CMD_POWER[15:8]);
			body.push_back(sfd_pkg::CMD_POWER[7:0]);
			body.push_back(8'($urandom));
			body.push_back(8'($urandom));
			body.push_back(8'($urandom));
			c = 8'h00;
			foreach (body[i]) begin
				c = crc_next(c, body[i]);
			end
			send_decoded(body[4:$]);
			send_decoded('{c});
			send_line_byte(sfd_pkg::DELIM);
			address_settings++;
		end
	endtask

	task automatic test_line_noise(input int count);
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 7))
				0: send_line_byte(sfd_pkg::DELIM);
				1: send_line_byte(sfd_pkg::ESC);
				2: send_line_byte(sfd_pkg::ESC_END);
				3: send_line_byte(sfd_pkg::ESC_ESC);
				default: send_line_byte(8'($urandom));
			endcase
		end
		send_line_byte(sfd_pkg::DELIM);
	endtask

	initial begin : result_monitor
		sfd_pkg::result_t got;
		sfd_pkg::result_t want;
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			got = {m_tdata[41:0], m_tuser};
			if (expected_frames.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				errors++;
			end else begin
				want = expected_frames.pop_front();
				check_field("frame_kind", want.frame_kind, got.frame_kind);
				check_field("crc_ok", want.crc_ok, got.crc_ok);
				check_field("address_ok", want.address_ok, got.address_ok);
				check_field("reading_value", want.reading_value, got.reading_value);
				check_field("frame_length", want.frame_length, got.frame_length);
				check_field("overflow", want.overflow, got.overflow);
				frames_checked++;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_line_escapes();
		test_meter_replies(20);
		set_meter_address(8'hFF, 8'hFF);
		steady = 1'b1;
		test_meter_replies(15);
		steady = 1'b0;
		set_meter_address(8'($urandom), 8'($urandom));
		test_meter_replies(20);
		test_address_change(3);
		set_meter_address(8'h00, 8'hFF);
		test_line_noise(150);
		set_meter_address(8'hC0, 8'hDB);
		test_meter_replies(20);

		wait_for_idle();
		repeat (4) @(posedge clk);
		$display("sent %0d line bytes, checked %0d decoded frames", line_bytes, frames_checked);
		$display("used %0d meter address settings, escapes, noise and over-long frames",
			address_settings);
		if (errors == 0 && expected_frames.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
